### rtl/sliding_median_box_smoother_assert.svh
// assertion macros shared by the smoother checker
`ifndef SLIDING_MEDIAN_BOX_SMOOTHER_ASSERT_SVH
`define SLIDING_MEDIAN_BOX_SMOOTHER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SMBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smoother check failed");

// next-cycle implication, disabled during reset
`define SMBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smoother check failed");

`endif

### rtl/smbs_pkg.sv
// shared constants and types of the sliding median box smoother
`default_nettype none

package smbs_pkg;

    localparam int LEFT_W      = 15;  // box_left / box_top width
    localparam int DIM_W       = 14;  // box_width / box_height width
    localparam int OUT_W       = 16;  // smooth_left / smooth_top width
    localparam int CFG_W       = 5;   // window_length register width
    localparam int WIN_RESET   = 5;   // window_length after reset
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;
    localparam int OQ_DEPTH    = 4;   // output queue entries
    localparam int OQ_PTR_W    = 2;
    localparam int OQ_CNT_W    = 3;

    // control handed from one cell to the next one up the chain
    typedef struct packed {
        logic ev_le;  // evicted sample sits at or below this cell
        logic g;      // compacted entry here is <= new sample
    } smbs_link_t;

endpackage

`default_nettype wire

### rtl/smbs_cell.sv
// one cell of the sorted sample chain: value, age, evict and insert logic
`default_nettype none

module smbs_cell
    import smbs_pkg::*;
#(
    parameter int VW  = 16,
    parameter int AW  = 4,
    parameter int CW  = 5,
    parameter int IDX = 0
)(
    input  wire logic                 clk,
    input  wire logic                 load,
    input  wire logic signed [VW-1:0] new_val,
    input  wire logic [AW-1:0]        win_m1,
    input  wire logic [CW-1:0]        cnt,
    input  wire logic [CW-1:0]        cntc,
    input  wire smbs_link_t           prev_link,
    input  wire logic signed [VW-1:0] prev_c_val,
    input  wire logic [AW-1:0]        prev_c_age,
    input  wire logic signed [VW-1:0] next_val,
    input  wire logic [AW-1:0]        next_age,
    input  wire logic                 next_le,
    output logic signed [VW-1:0]      val,
    output logic [AW-1:0]             age,
    output logic                      le,
    output smbs_link_t                link_out,
    output logic signed [VW-1:0]      c_val,
    output logic [AW-1:0]             c_age
);

    logic signed [VW-1:0] val_reg;
    logic signed [VW-1:0] val_next;
    logic [AW-1:0]        age_reg;
    logic [AW-1:0]        age_next;
    logic                 vld;
    logic                 c_vld;
    logic                 ev_le;
    logic                 g;

    always_comb
    begin
        vld   = cnt > CW'(IDX);
        ev_le = prev_link.ev_le | (vld & (age_reg == win_m1));
        le    = val_reg <= new_val;
        // compaction: cells above the evicted one move down by one
        c_val = ev_le ? next_val : val_reg;
        c_age = ev_le ? next_age : age_reg;
        c_vld = cntc > CW'(IDX);
        g     = c_vld & (ev_le ? next_le : le);
        // insertion: keep own entry, take new sample, or take the one below
        if (g)
        begin
            val_next = c_val;
            age_next = c_age + AW'(1);
        end
        else if (prev_link.g)
        begin
            val_next = new_val;
            age_next = '0;
        end
        else
        begin
            val_next = prev_c_val;
            age_next = prev_c_age + AW'(1);
        end
        link_out.ev_le = ev_le;
        link_out.g     = g;
        val            = val_reg;
        age            = age_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

`default_nettype wire

### rtl/smbs_chain.sv
// row of sorted cells for one coordinate history, with rank select
`default_nettype none

module smbs_chain
    import smbs_pkg::*;
#(
    parameter int VW   = 16,
    parameter int WMAX = 16,
    parameter int AW   = (WMAX > 1) ? $clog2(WMAX) : 1,
    parameter int CW   = $clog2(WMAX + 1)
)(
    input  wire logic                 clk,
    input  wire logic                 load,
    input  wire logic signed [VW-1:0] new_val,
    input  wire logic [AW-1:0]        win_m1,
    input  wire logic [CW-1:0]        cnt,
    input  wire logic [CW-1:0]        cntc,
    input  wire logic [AW-1:0]        rank,
    output logic signed [VW-1:0]      median
);

    logic signed [VW-1:0] val_a  [WMAX];
    logic [AW-1:0]        age_a  [WMAX];
    logic                 le_a   [WMAX];
    smbs_link_t           link_a [WMAX];
    logic signed [VW-1:0] cval_a [WMAX];
    logic [AW-1:0]        cage_a [WMAX];

    for (genvar i = 0; i < WMAX; i++)
    begin : g_cell
        smbs_link_t           p_link;
        logic signed [VW-1:0] p_cval;
        logic [AW-1:0]        p_cage;
        logic signed [VW-1:0] n_val;
        logic [AW-1:0]        n_age;
        logic                 n_le;

        if (i == 0)
        begin : g_bottom
            // below the first cell: nothing evicted, new sample goes here
            assign p_link = '{ev_le: 1'b0, g: 1'b1};
            assign p_cval = '0;
            assign p_cage = '0;
        end
        else
        begin : g_lower
            assign p_link = link_a[i-1];
            assign p_cval = cval_a[i-1];
            assign p_cage = cage_a[i-1];
        end

        if (i == WMAX - 1)
        begin : g_top
            assign n_val = '0;
            assign n_age = '0;
            assign n_le  = 1'b0;
        end
        else
        begin : g_upper
            assign n_val = val_a[i+1];
            assign n_age = age_a[i+1];
            assign n_le  = le_a[i+1];
        end

        smbs_cell #(
            .VW  (VW),
            .AW  (AW),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .load       (load),
            .new_val    (new_val),
            .win_m1     (win_m1),
            .cnt        (cnt),
            .cntc       (cntc),
            .prev_link  (p_link),
            .prev_c_val (p_cval),
            .prev_c_age (p_cage),
            .next_val   (n_val),
            .next_age   (n_age),
            .next_le    (n_le),
            .val        (val_a[i]),
            .age        (age_a[i]),
            .le         (le_a[i]),
            .link_out   (link_a[i]),
            .c_val      (cval_a[i]),
            .c_age      (cage_a[i])
        );
    end

    assign median = val_a[rank];

endmodule

`default_nettype wire

### rtl/sliding_median_box_smoother.sv
// Sliding median box smoother. Each accepted item is one box (left, top, width, height).
// Its center (left + width/2, top + height/2) enters two chains of cells, one per
// coordinate, that keep the last window_length centers sorted together with their
// ages; on every item the new sample slides into place, and once the window is full the
// oldest sample leaves in the same update, so the block takes one item per clock cycle
// while the output queue has room. The result item carries the lower median of each
// history (sorted element at index (n-1)/2 of the n samples held) with a box of the
// input size rebuilt around it. A result item passes through the median stage and is
// written into the output queue before it shows on the master side; the four-item
// output queue lets input keep flowing while results wait, and input is held off once
// four items are in flight.
// Writing window_length (0 acts as 1, values above WINDOW_MAX saturate) empties
// both histories; write it only while no item is in flight. No clearing pass
// follows reset.
`default_nettype none

module sliding_median_box_smoother
    import smbs_pkg::*;
#(
    parameter int WINDOW_MAX = 16,
    parameter int COORD_BITS = 16
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // config channel: window_length[4:0]
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_W-1:0]       cfg_data,
    // input items
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // box_left[14:0], box_top[29:15], box_width[43:30], box_height[57:44], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result items
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // smooth_left[15:0], smooth_top[31:16], smooth_width[45:32],
    // smooth_height[59:46], zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW     = $clog2(WINDOW_MAX + 1);
    localparam int HALF_W = DIM_W - 1;
    localparam int SUM_W  = LEFT_W + 2;
    localparam int EXT_W  = (COORD_BITS > SUM_W) ? COORD_BITS : SUM_W;
    localparam int DW     = (COORD_BITS > OUT_W) ? COORD_BITS : OUT_W;
    localparam int ITEM_W = 2 * OUT_W + 2 * DIM_W;
    localparam int WIN_RST_EFF = (WIN_RESET > WINDOW_MAX) ? WINDOW_MAX : WIN_RESET;

    // input field unpacking
    logic signed [LEFT_W-1:0] box_left;
    logic signed [LEFT_W-1:0] box_top;
    logic [DIM_W-1:0]         box_width;
    logic [DIM_W-1:0]         box_height;
    logic [HALF_W-1:0]        half_w;
    logic [HALF_W-1:0]        half_h;

    assign box_left   = s_axis_tdata[LEFT_W-1:0];
    assign box_top    = s_axis_tdata[2*LEFT_W-1:LEFT_W];
    assign box_width  = s_axis_tdata[2*LEFT_W+DIM_W-1:2*LEFT_W];
    assign box_height = s_axis_tdata[2*LEFT_W+2*DIM_W-1:2*LEFT_W+DIM_W];
    assign half_w     = box_width[DIM_W-1:1];
    assign half_h     = box_height[DIM_W-1:1];

    logic in_fire;
    logic cfg_fire;
    logic out_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign in_fire   = s_axis_tvalid & s_axis_tready;
    assign out_fire  = m_axis_tvalid & m_axis_tready;

    // centers, wrapped to the history width
    logic signed [SUM_W-1:0]      cx_sum;
    logic signed [SUM_W-1:0]      cy_sum;
    logic signed [EXT_W-1:0]      cx_ext;
    logic signed [EXT_W-1:0]      cy_ext;
    logic signed [COORD_BITS-1:0] centre_x;
    logic signed [COORD_BITS-1:0] centre_y;

    assign cx_sum   = SUM_W'(box_left) + $signed(SUM_W'(half_w));
    assign cy_sum   = SUM_W'(box_top) + $signed(SUM_W'(half_h));
    assign cx_ext   = EXT_W'(cx_sum);
    assign cy_ext   = EXT_W'(cy_sum);
    assign centre_x = cx_ext[COORD_BITS-1:0];
    assign centre_y = cy_ext[COORD_BITS-1:0];

    // window and fill count, shared by both chains
    logic [CW-1:0] win_reg;
    logic [CW-1:0] win_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] cntc;
    logic [AW-1:0] win_m1;
    logic          full;

    always_comb
    begin
        // window register saturates on write; zero acts as one
        priority if (cfg_data == '0)
            win_next = CW'(1);
        else if (int'(cfg_data) > WINDOW_MAX)
            win_next = CW'(WINDOW_MAX);
        else
            win_next = CW'(cfg_data);
    end

    assign win_m1   = AW'(win_reg - CW'(1));
    assign full     = cnt_reg == win_reg;
    // count after the oldest sample leaves, then after the new one enters
    assign cntc     = cnt_reg - CW'(full);
    assign cnt_next = cntc + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= CW'(WIN_RST_EFF);
            cnt_reg <= '0;
        end
        else if (cfg_fire)
        begin
            win_reg <= win_next;
            cnt_reg <= '0;
        end
        else if (in_fire)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // sorted histories
    logic [AW-1:0]                rank;
    logic signed [COORD_BITS-1:0] med_x;
    logic signed [COORD_BITS-1:0] med_y;

    // read while the item sits in the median stage; cnt_reg still holds its count
    assign rank = AW'((cnt_reg - CW'(1)) >> 1);

    smbs_chain #(
        .VW   (COORD_BITS),
        .WMAX (WINDOW_MAX)
    ) u_chain_x (
        .clk     (clk),
        .load    (in_fire),
        .new_val (centre_x),
        .win_m1  (win_m1),
        .cnt     (cnt_reg),
        .cntc    (cntc),
        .rank    (rank),
        .median  (med_x)
    );

    smbs_chain #(
        .VW   (COORD_BITS),
        .WMAX (WINDOW_MAX)
    ) u_chain_y (
        .clk     (clk),
        .load    (in_fire),
        .new_val (centre_y),
        .win_m1  (win_m1),
        .cnt     (cnt_reg),
        .cntc    (cntc),
        .rank    (rank),
        .median  (med_y)
    );

    // median stage: box size travels alongside the chain update
    logic              p1_valid_reg;
    logic [HALF_W-1:0] p1_hw_reg;
    logic [HALF_W-1:0] p1_hh_reg;
    logic [DIM_W-1:0]  p1_w_reg;
    logic [DIM_W-1:0]  p1_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= in_fire;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            p1_hw_reg <= half_w;
            p1_hh_reg <= half_h;
            p1_w_reg  <= box_width;
            p1_h_reg  <= box_height;
        end
    end

    // rebuild the box around the median center
    logic signed [DW-1:0] left_diff;
    logic signed [DW-1:0] top_diff;
    logic [ITEM_W-1:0]    out_item;

    assign left_diff = DW'(med_x) - $signed(DW'(p1_hw_reg));
    assign top_diff  = DW'(med_y) - $signed(DW'(p1_hh_reg));
    assign out_item  = {p1_h_reg, p1_w_reg, top_diff[OUT_W-1:0], left_diff[OUT_W-1:0]};

    // output queue; input is held off early enough that it never overflows
    logic [ITEM_W-1:0]   oq_mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_reg;
    logic [OQ_PTR_W-1:0] oq_rd_reg;
    logic [OQ_CNT_W-1:0] oq_cnt_reg;
    logic [OQ_CNT_W-1:0] oq_cnt_next;
    logic [OQ_CNT_W-1:0] occupancy;

    assign occupancy     = OQ_CNT_W'(p1_valid_reg) + oq_cnt_reg;
    assign s_axis_tready = occupancy < OQ_CNT_W'(OQ_DEPTH);
    assign oq_cnt_next   = oq_cnt_reg + OQ_CNT_W'(p1_valid_reg) - OQ_CNT_W'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (p1_valid_reg)
                oq_wr_reg <= oq_wr_reg + OQ_PTR_W'(1);
            if (out_fire)
                oq_rd_reg <= oq_rd_reg + OQ_PTR_W'(1);
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
            oq_mem_reg[oq_wr_reg] <= out_item;
    end

    assign m_axis_tvalid = oq_cnt_reg != '0;
    assign m_axis_tdata  = {(OUT_TDATA_W - ITEM_W)'(0), oq_mem_reg[oq_rd_reg]};

endmodule

`default_nettype wire

### rtl/smbs_checker.sv
// port-level checker for the smoother, bound to the top level
`default_nettype none

`include "sliding_median_box_smoother_assert.svh"

module smbs_port_checker
    import smbs_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready,
    input wire logic [CFG_W-1:0]       cfg_data,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [OQ_CNT_W-1:0] inflight_reg;
    logic [OQ_CNT_W-1:0] inflight_next;
    logic                in_fire;
    logic                out_fire;
    logic                cfg_seen;

    assign in_fire  = s_axis_tvalid & s_axis_tready;
    assign out_fire = m_axis_tvalid & m_axis_tready;
    // config content is not checked here, only that the channel exists
    assign cfg_seen = cfg_valid & cfg_ready & (cfg_data == cfg_data);

    assign inflight_next = inflight_reg + OQ_CNT_W'(in_fire) - OQ_CNT_W'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // a result only exists for an item already taken
    `SMBS_ASSERT_IMP(a_no_phantom_result, clk, rst_n, m_axis_tvalid, inflight_reg != '0)

    // an empty block always takes input
    `SMBS_ASSERT_IMP(a_ready_when_empty, clk, rst_n, inflight_reg == '0 && !cfg_seen,
        s_axis_tready)

    // input is held off before the output queue could overflow
    `SMBS_ASSERT_IMP(a_backpressure, clk, rst_n,
        inflight_reg >= OQ_CNT_W'(OQ_DEPTH), !s_axis_tready)

    // a stalled result holds
    `SMBS_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    // input data is observed only through the handshake
    `SMBS_ASSERT_IMP(a_in_known, clk, rst_n, in_fire, s_axis_tdata == s_axis_tdata)

endmodule

bind sliding_median_box_smoother smbs_port_checker u_smbs_checker (.*);

`default_nettype wire

### tb/smbs_checker.sv
// passive checker: predicts each smoothed box and compares it with the result stream
module smbs_checker
    import smbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output int                          mismatch_count,
    output int                          boxes_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH = 16;

    typedef logic signed [OUT_W-1:0] coord_t;
    typedef coord_t coord_hist_t [HIST_DEPTH];

    typedef struct packed {
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
        logic [OUT_W-1:0] top;
        logic [OUT_W-1:0] left;
    } smooth_box_t;

    logic [CFG_W-1:0] window_reg = CFG_W'(WIN_RESET);
    coord_hist_t      center_x_hist;
    coord_hist_t      center_y_hist;
    int               centers_kept = 0;
    int               mismatches = 0;
    int               pending_boxes = 0;
    smooth_box_t      expected_boxes [$];
    smooth_box_t      seen_box;
    smooth_box_t      oldest_box;

    assign mismatch_count    = mismatches;
    assign boxes_outstanding = pending_boxes;

    function automatic int effective_window(input logic [CFG_W-1:0] w);
        if (w == '0)
            return 1;
        if (int'(w) > HIST_DEPTH)
            return HIST_DEPTH;
        return int'(w);
    endfunction

    // insertion sort of the first n samples, lower middle element
    function automatic coord_t lower_median(input coord_hist_t hist, input int n);
        coord_t sorted_vals [HIST_DEPTH];
        coord_t v;
        int     i;
        int     j;
        for (i = 0; i < n; i++)
        begin
            v = hist[i];
            j = i;
            while (j > 0 && sorted_vals[j-1] > v)
            begin
                sorted_vals[j] = sorted_vals[j-1];
                j--;
            end
            sorted_vals[j] = v;
        end
        return sorted_vals[(n - 1) / 2];
    endfunction

    task automatic predict_box(input logic [IN_TDATA_W-1:0] item);
        logic signed [LEFT_W-1:0] left_in;
        logic signed [LEFT_W-1:0] top_in;
        logic [DIM_W-1:0]         w_in;
        logic [DIM_W-1:0]         h_in;
        int                       half_w;
        int                       half_h;
        int                       win;
        int                       n;
        coord_t                   mid_x;
        coord_t                   mid_y;
        smooth_box_t              box;
        left_in = item[LEFT_W-1:0];
        top_in  = item[2*LEFT_W-1:LEFT_W];
        w_in    = item[2*LEFT_W+DIM_W-1:2*LEFT_W];
        h_in    = item[2*LEFT_W+2*DIM_W-1:2*LEFT_W+DIM_W];
        half_w  = int'(w_in >> 1);
        half_h  = int'(h_in >> 1);
        win     = effective_window(window_reg);
        if (centers_kept >= win)
            centers_kept = win - 1;
        center_x_hist[centers_kept] = coord_t'(int'(left_in) + half_w);
        center_y_hist[centers_kept] = coord_t'(int'(top_in) + half_h);
        n = centers_kept + 1;
        mid_x = lower_median(center_x_hist, n);
        mid_y = lower_median(center_y_hist, n);
        if (n == win)
        begin
            // oldest sample leaves the window
            for (int k = 1; k < n; k++)
            begin
                center_x_hist[k-1] = center_x_hist[k];
                center_y_hist[k-1] = center_y_hist[k];
            end
            centers_kept = n - 1;
        end
        else
            centers_kept = n;
        box.left   = OUT_W'(int'(mid_x) - half_w);
        box.top    = OUT_W'(int'(mid_y) - half_h);
        box.width  = w_in;
        box.height = h_in;
        expected_boxes = {expected_boxes, box};
    endtask

    task automatic compare_field(input string field_name, input logic signed [31:0] want_v,
                                 input logic signed [31:0] seen_v);
        if (want_v !== seen_v)
        begin
            $error("%s: expected %0d, got %0d", field_name, want_v, seen_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   = CFG_W'(WIN_RESET);
            centers_kept = 0;
            expected_boxes.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_box = m_axis_tdata[2*OUT_W+2*DIM_W-1:0];
                if (expected_boxes.size() == 0)
                begin
                    $error("result item with no expected box pending");
                    mismatches++;
                end
                else
                begin
                    oldest_box = expected_boxes.pop_front();
                    compare_field("smooth_left", $signed(oldest_box.left), $signed(seen_box.left));
                    compare_field("smooth_top", $signed(oldest_box.top), $signed(seen_box.top));
                    compare_field("smooth_width", oldest_box.width, seen_box.width);
                    compare_field("smooth_height", oldest_box.height, seen_box.height);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                window_reg   = cfg_data;
                centers_kept = 0;
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_box(s_axis_tdata);
        end
        pending_boxes = expected_boxes.size();
    end

endmodule

### tb/testbench.sv
// top of the sliding median box smoother testbench: clock, reset, stimulus and verdict
module testbench;
    import smbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;       // long receiver hold-off, fills the output queue
    localparam int PHASE_ITEMS = 40;        // random items per window setting
    localparam int PHASES      = 10;
    localparam int TIMEOUT_NS  = 4_000_000; // far beyond the slowest legal run

    localparam logic [LEFT_W-1:0] COORD_MIN = 15'h4000;  // -16384
    localparam logic [LEFT_W-1:0] COORD_MAX = 15'h3fff;  // 16383
    localparam logic [DIM_W-1:0]  DIM_MAX   = 14'h3fff;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_EVERY4,
        RX_TRICKLE
    } rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int boxes_outstanding;
    bit hold_req = 1'b0;     // asks the result sink for one long hold-off
    int burst_left = 0;      // items left in the current sender burst

    // tracked object for well-formed box sequences
    int               track_x;
    int               track_y;
    logic [DIM_W-1:0] track_w;
    logic [DIM_W-1:0] track_h;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sliding_median_box_smoother DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    smbs_checker box_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .mismatch_count    (mismatch_count),
        .boxes_outstanding (boxes_outstanding)
    );

    // clamp a coordinate into the signed 15-bit input range
    function automatic logic [LEFT_W-1:0] clamp_coord(input int v);
        if (v < -16384)
            v = -16384;
        if (v > 16383)
            v = 16383;
        return LEFT_W'(v);
    endfunction

    // offer one box item, called at a falling edge; valid stays high inside a burst
    // and drops for a random gap between bursts
    task automatic send_box(input logic [LEFT_W-1:0] bl, input logic [LEFT_W-1:0] bt,
                            input logic [DIM_W-1:0] bw, input logic [DIM_W-1:0] bh);
        int gap;
        s_axis_tdata  <= {{(IN_TDATA_W-2*LEFT_W-2*DIM_W){1'b0}}, bh, bw, bt, bl};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // stop offering and wait until every predicted box has come back
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        wait (boxes_outstanding == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] win);
        cfg_data  <= win;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result sink: its own stall pattern, picked anew from a phase counter,
    // plus one long hold-off when asked
    initial
    begin : result_sink
        rx_mode_t rx_mode;
        int       rx_phase;
        rx_mode  = RX_OPEN;
        rx_phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (rx_phase % 48 == 0)
            begin
                if ($urandom_range(0, 4) == 4)
                    rx_mode = RX_OPEN;
                else
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
            end
            rx_phase++;
            case (rx_mode)
                RX_OPEN:    m_axis_tready <= 1'b1;
                RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                RX_EVERY4:  m_axis_tready <= (rx_phase % 4 == 0);
                RX_TRICKLE: m_axis_tready <= ($urandom_range(0, 7) == 0);
                default:    m_axis_tready <= 1'b1;
            endcase
        end
    end

    initial
    begin : stimulus
        int               i;
        int               p;
        int               kind;
        logic [CFG_W-1:0] win;
        logic [LEFT_W-1:0] bl;
        logic [LEFT_W-1:0] bt;
        logic [DIM_W-1:0]  bw;
        logic [DIM_W-1:0]  bh;

        // reset held, then released once, on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);
        burst_left = $urandom_range(0, 8);

        // directed part at the reset window of five
        // field extremes, including zero and full size boxes
        send_box(COORD_MIN, COORD_MIN, '0, '0);
        send_box(COORD_MAX, COORD_MAX, DIM_MAX, DIM_MAX);
        send_box(COORD_MIN, COORD_MAX, DIM_MAX, '0);
        send_box(COORD_MAX, COORD_MIN, '0, DIM_MAX);
        send_box('0, '0, DIM_W'(1), DIM_W'(1));
        // ascending x and descending y, odd sizes round half down
        for (i = 0; i < 6; i++)
            send_box(clamp_coord(100 * i), clamp_coord(-100 * i),
                     DIM_W'(2 * i + 1), DIM_W'(2 * i + 3));
        // ties in the history
        for (i = 0; i < 3; i++)
            send_box(LEFT_W'(50), LEFT_W'(50), DIM_W'(10), DIM_W'(10));
        // a single spike that the median should reject
        send_box(COORD_MAX, COORD_MIN, DIM_W'(10), DIM_W'(10));
        send_box(LEFT_W'(52), LEFT_W'(48), DIM_W'(10), DIM_W'(10));
        // run descending in x and ascending in y pushes samples out of the full window
        for (i = 0; i < 5; i++)
            send_box(clamp_coord(2000 - 300 * i), clamp_coord(-2000 + 300 * i),
                     DIM_W'(64), DIM_W'(33));

        // random part: one window setting per phase, window written while idle
        for (p = 0; p < PHASES; p++)
        begin
            settle_idle();
            case (p)
                0: win = CFG_W'(1);
                1: win = CFG_W'(16);
                2: win = CFG_W'(0);    // zero behaves as a window of one
                3: win = CFG_W'(31);   // saturates to sixteen
                4: win = CFG_W'(3);
                5: win = CFG_W'(17);
                6: win = CFG_W'(2);
                7: win = CFG_W'($urandom_range(0, 31));
                8: win = CFG_W'(8);
                default: win = CFG_W'(WIN_RESET);
            endcase
            write_window(win);

            // new object to follow in this phase
            track_x = int'($urandom_range(0, 32767)) - 16384;
            track_y = int'($urandom_range(0, 32767)) - 16384;
            track_w = DIM_W'($urandom_range(0, 16383));
            track_h = DIM_W'($urandom_range(0, 16383));

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // result side holds off while items keep coming, so the block backs up
                if (p == 1 && i == 8)
                    hold_req = 1'b1;
                // one pause mid-phase until every result is back
                if (p == 5 && i == 20)
                    settle_idle();

                kind = $urandom_range(0, 9);
                if (kind <= 5)
                begin
                    // tracked object: slow drift with jitter, size nearly steady
                    track_x += int'($urandom_range(0, 6)) - 3;
                    track_y += int'($urandom_range(0, 6)) - 3;
                    bl = clamp_coord(track_x + int'($urandom_range(0, 16)) - 8);
                    bt = clamp_coord(track_y + int'($urandom_range(0, 16)) - 8);
                    bw = track_w + DIM_W'($urandom_range(0, 2));
                    bh = track_h + DIM_W'($urandom_range(0, 2));
                end
                else if (kind <= 7)
                begin
                    // noise: any box at all
                    bl = LEFT_W'($urandom);
                    bt = LEFT_W'($urandom);
                    bw = DIM_W'($urandom);
                    bh = DIM_W'($urandom);
                end
                else if (kind == 8)
                begin
                    // corners of the field ranges
                    bl = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                    bt = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                    bw = $urandom_range(0, 1) ? DIM_MAX : '0;
                    bh = $urandom_range(0, 1) ? DIM_MAX : '0;
                end
                else
                begin
                    // false detection in x only, the track goes on in y
                    bl = LEFT_W'($urandom);
                    bt = clamp_coord(track_y);
                    bw = track_w;
                    bh = track_h;
                end
                send_box(bl, bt, bw, bh);
            end
        end

        // drain, then wait for anything stray to show up
        settle_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hard stop if the handshakes hang
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/smbs_pkg.sv
rtl/smbs_cell.sv
rtl/smbs_chain.sv
rtl/sliding_median_box_smoother.sv
rtl/smbs_checker.sv
tb/smbs_checker.sv
tb/testbench.sv
